// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file tirf_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tirf_pkg.sv =====
// Types and constants for the Telnet IAC receive filter.
// No dependencies.
`default_nettype none
package tirf_pkg;

    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_DONT = 8'd254;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] BYTE_ZERO = 8'd0;

    localparam logic [1:0] VERB_DO = 2'd2;

    typedef enum logic [2:0] {
        PH_DATA = 3'b001,
        PH_IAC  = 3'b010,
        PH_OPT  = 3'b100
    } phase_t;

    // Decoded action for one input beat.
    typedef struct packed {
        logic       reply;   // 1: send IAC WILL SGA to peer
        logic [7:0] data;    // host data byte
    } act_t;

endpackage
`default_nettype wire

// ===== src/tirf_parse.sv =====
// Command parser: phase state plus registered action per input beat.
// Depends on tirf_pkg.
`default_nettype none
module tirf_parse
    import tirf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       binary_mode,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    output logic            in_ready,
    output logic            act_valid,
    output act_t            act,
    input  wire logic       act_ready
);

    phase_t     phase_reg, phase_next;
    logic [1:0] verb_reg, verb_next;
    logic       act_valid_reg, act_valid_next;
    act_t       act_reg, act_next;
    logic       res_valid;
    act_t       res;
    logic       in_take;

    assign in_ready  = !act_valid_reg || act_ready;
    assign in_take   = in_valid && in_ready;
    assign act_valid = act_valid_reg;
    assign act       = act_reg;

    always_comb begin
        res_valid  = 1'b0;
        res.reply  = 1'b0;
        res.data   = in_byte;
        phase_next = PH_DATA;
        verb_next  = verb_reg;
        case (phase_reg)
            PH_IAC: begin
                if (in_byte == CODE_IAC) begin
                    res_valid = 1'b1;
                end else if (in_byte >= CODE_WILL && in_byte <= CODE_DONT) begin
                    verb_next  = 2'(in_byte - CODE_WILL);
                    phase_next = PH_OPT;
                end
            end
            PH_OPT: begin
                if (verb_reg == VERB_DO && in_byte == OPT_SGA) begin
                    res_valid = 1'b1;
                    res.reply = 1'b1;
                end
            end
            default: begin
                if (in_byte == CODE_IAC) begin
                    phase_next = PH_IAC;
                end else if (in_byte != BYTE_ZERO || binary_mode) begin
                    res_valid = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        act_valid_next = act_valid_reg;
        act_next       = act_reg;
        if (in_take) begin
            act_valid_next = res_valid;
            act_next       = res;
        end else if (act_ready) begin
            act_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_DATA;
            verb_reg      <= 2'd0;
            act_valid_reg <= 1'b0;
        end else begin
            act_valid_reg <= act_valid_next;
            if (in_take) begin
                phase_reg <= phase_next;
                verb_reg  <= verb_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg <= act_next;
    end

endmodule
`default_nettype wire

// ===== src/tirf_out.sv =====
// Result register: host data beats and the three-beat reply burst.
// Depends on tirf_pkg.
`default_nettype none
module tirf_out
    import tirf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       act_valid,
    input  wire act_t       act,
    output logic            act_ready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tuser,
    output logic            m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       dest_reg, dest_next;
    logic       last_reg, last_next;
    logic [1:0] burst_reg, burst_next;   // reply beats still to load
    logic       slot_free;

    assign slot_free = !valid_reg || m_tready;
    assign act_ready = slot_free && (burst_reg == 2'd0);

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = dest_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        dest_next  = dest_reg;
        last_next  = last_reg;
        burst_next = burst_reg;
        if (slot_free) begin
            if (burst_reg == 2'd2) begin
                valid_next = 1'b1;
                byte_next  = CODE_WILL;
                dest_next  = 1'b1;
                last_next  = 1'b0;
                burst_next = 2'd1;
            end else if (burst_reg == 2'd1) begin
                valid_next = 1'b1;
                byte_next  = OPT_SGA;
                dest_next  = 1'b1;
                last_next  = 1'b1;
                burst_next = 2'd0;
            end else if (act_valid) begin
                valid_next = 1'b1;
                if (act.reply) begin
                    byte_next  = CODE_IAC;
                    dest_next  = 1'b1;
                    last_next  = 1'b0;
                    burst_next = 2'd2;
                end else begin
                    byte_next  = act.data;
                    dest_next  = 1'b0;
                    last_next  = 1'b1;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            burst_reg <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            burst_reg <= burst_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        dest_reg <= dest_next;
        last_reg <= last_next;
    end

endmodule
`default_nettype wire

// ===== src/telnet_iac_receive_filter_core.sv =====
// Telnet IAC receive filter: parser stage and result stage.
// Each input beat is registered in the parser stage and then in the result stage.
// Throughput: one input beat per cycle while the output is not stalled; an
// answered DO SGA holds input while the three-beat reply goes out.
// Reset (aresetn low, synchronous): data phase, empty stages, binary mode off.
// Depends on tirf_pkg, tirf_parse, tirf_out.
`default_nettype none
module telnet_iac_receive_filter_core
    import tirf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,   // binary_mode
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // [7:0] out_byte
    output logic            m_tuser,       // [0] out_dest
    output logic            m_tlast        // out_last
);

    logic binary_mode_reg;
    logic act_valid;
    logic act_ready;
    act_t act;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binary_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            binary_mode_reg <= cfg_wr_data;
        end
    end

    tirf_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .binary_mode (binary_mode_reg),
        .in_valid    (s_tvalid),
        .in_byte     (s_tdata),
        .in_ready    (s_tready),
        .act_valid   (act_valid),
        .act         (act),
        .act_ready   (act_ready)
    );

    tirf_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .act_valid (act_valid),
        .act       (act),
        .act_ready (act_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// ===== src/tirf_checker.sv =====
// Port-level checks for the Telnet IAC receive filter, bound to the top level.
// Depends on tirf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tirf_checker
    import tirf_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    `ASSERT_NOW(a_host_last, aclk, aresetn, m_tvalid && !m_tuser, m_tlast,
                "host beat without tlast")

    `ASSERT_NEXT(a_reply_will, aclk, aresetn,
                 m_tvalid && m_tready && m_tuser && !m_tlast && m_tdata == CODE_IAC,
                 m_tvalid && m_tuser && !m_tlast && m_tdata == CODE_WILL,
                 "reply IAC not followed by WILL")

    `ASSERT_NEXT(a_reply_opt, aclk, aresetn,
                 m_tvalid && m_tready && m_tuser && m_tdata == CODE_WILL,
                 m_tvalid && m_tuser && m_tlast && m_tdata == OPT_SGA,
                 "reply WILL not followed by SGA")

    `ASSERT_NOW(a_reply_last, aclk, aresetn, m_tvalid && m_tuser && m_tlast,
                m_tdata == OPT_SGA, "last reply beat is not the SGA option")

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
                 "stalled result beat changed")

endmodule

bind telnet_iac_receive_filter_core tirf_checker u_tirf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for telnet_iac_receive_filter_core: a directed byte table and then
// random Telnet streams, with every result beat checked against the table or a local model.
// Depends on tirf_pkg and the filter RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tirf_pkg::*;

    localparam logic [7:0] CODE_WONT = 8'd252;
    localparam logic [7:0] CODE_DO   = 8'd253;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_SE   = 8'd240;
    localparam int         STALL_LIMIT = 2000;
    localparam int         RANDOM_ITEMS = 144;

    typedef enum logic [2:0] {
        ST_DATA = 3'b001,
        ST_IAC  = 3'b010,
        ST_OPT  = 3'b100
    } parse_st_t;
    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_DATA, CHK_REPLY} chk_t;

    typedef struct packed {
        logic [7:0] data;
        logic       to_peer;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [7:0] rx;
        chk_t       kind;
        logic [7:0] val;
    } row_t;

    localparam int N_ROWS = 28;
    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        '{8'h41,     CHK_DATA,  8'h41},
        '{BYTE_ZERO, CHK_NONE,  8'h00},
        '{8'hFE,     CHK_DATA,  8'hFE},
        '{CODE_IAC,  CHK_NONE,  8'h00},
        '{CODE_IAC,  CHK_DATA,  CODE_IAC},
        '{CODE_IAC,  CHK_NONE,  8'h00},
        '{CODE_DO,   CHK_NONE,  8'h00},
        '{OPT_SGA,   CHK_REPLY, 8'h00},
        '{CODE_IAC,  CHK_NONE,  8'h00},
        '{CODE_WILL, CHK_NONE,  8'h00},
        '{OPT_SGA,   CHK_NONE,  8'h00},
        '{CODE_IAC,  CHK_NONE,  8'h00},
        '{CODE_WONT, CHK_NONE,  8'h00},
        '{CODE_IAC,  CHK_NONE,  8'h00},   // option byte 255 is just an option
        '{CODE_IAC,  CHK_NONE,  8'h00},
        '{CODE_DONT, CHK_NONE,  8'h00},
        '{OPT_SGA,   CHK_NONE,  8'h00},
        '{CODE_IAC,  CHK_NONE,  8'h00},
        '{CODE_DO,   CHK_NONE,  8'h00},
        '{8'h04,     CHK_NONE,  8'h00},
        '{CODE_IAC,  CHK_NONE,  8'h00},
        '{CODE_SB,   CHK_NONE,  8'h00},
        '{BYTE_ZERO, CHK_NONE,  8'h00},   // plain data after SB, binary off
        '{CODE_IAC,  CHK_NONE,  8'h00},
        '{CODE_SE,   CHK_NONE,  8'h00},
        '{CODE_IAC,  CHK_NONE,  8'h00},
        '{BYTE_ZERO, CHK_NONE,  8'h00},   // zero command byte
        '{8'h80,     CHK_PRED,  8'h00}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    parse_st_t  parse_st = ST_DATA;
    logic [1:0] held_verb = 2'd0;
    logic       binary_on = 1'b0;
    beat_t      expected_beats[$];
    int         mismatches = 0;
    int         src_idle_pct = 16;
    int         dst_idle_pct = 79;
    int         quiet_cycles = 0;

    telnet_iac_receive_filter_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Next state of the IAC parser; appends the beats this byte causes.
    function automatic void filter_byte(input logic [7:0] b, ref beat_t res[$]);
        case (parse_st)
            ST_IAC: begin
                parse_st = ST_DATA;
                if (b == CODE_IAC) begin
                    res.push_back(beat_t'{CODE_IAC, 1'b0, 1'b1});
                end else if (b >= CODE_WILL && b <= CODE_DONT) begin
                    held_verb = 2'(b - CODE_WILL);
                    parse_st = ST_OPT;
                end
            end
            ST_OPT: begin
                parse_st = ST_DATA;
                if (held_verb == VERB_DO && b == OPT_SGA) begin
                    res.push_back(beat_t'{CODE_IAC, 1'b1, 1'b0});
                    res.push_back(beat_t'{CODE_WILL, 1'b1, 1'b0});
                    res.push_back(beat_t'{OPT_SGA, 1'b1, 1'b1});
                end
            end
            default: begin
                parse_st = ST_DATA;
                if (b == CODE_IAC) begin
                    parse_st = ST_IAC;
                end else if (b != BYTE_ZERO || binary_on) begin
                    res.push_back(beat_t'{b, 1'b0, 1'b1});
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input chk_t kind, input logic [7:0] val);
        beat_t got[$];
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        filter_byte(b, got);
        case (kind)
            CHK_PRED:  foreach (got[i]) expected_beats.push_back(got[i]);
            CHK_DATA:  expected_beats.push_back(beat_t'{val, 1'b0, 1'b1});
            CHK_REPLY: begin
                expected_beats.push_back(beat_t'{CODE_IAC, 1'b1, 1'b0});
                expected_beats.push_back(beat_t'{CODE_WILL, 1'b1, 1'b0});
                expected_beats.push_back(beat_t'{OPT_SGA, 1'b1, 1'b1});
            end
            default: ;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_binary_mode(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        binary_on = v;
    endtask

    task automatic run_random(input int count);
        logic [7:0] seq[$];
        int         sent;
        int         pick;
        int         optsel;
        sent = 0;
        while (sent < count) begin
            seq.delete();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                seq.push_back(($urandom_range(0, 7) == 0) ? BYTE_ZERO
                                                          : 8'($urandom_range(0, 254)));
            end else if (pick < 52) begin
                seq = '{CODE_IAC, CODE_IAC};
            end else if (pick < 70) begin
                seq = '{CODE_IAC, CODE_DO, OPT_SGA};
            end else if (pick < 86) begin
                seq.push_back(CODE_IAC);
                seq.push_back(8'(CODE_WILL + $urandom_range(0, 3)));
                optsel = $urandom_range(0, 7);
                seq.push_back((optsel < 2) ? OPT_SGA :
                              (optsel == 2) ? CODE_IAC : 8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                seq.push_back(CODE_IAC);
                seq.push_back(8'($urandom_range(0, 250)));
            end else begin
                repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(0, 255)));
            end
            foreach (seq[i]) send_byte(seq[i], CHK_PRED, 8'h00);
            sent += seq.size();
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: out_byte %0d out_dest %0d", m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte: expected %0d, got %0d", want.data, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.to_peer) begin
                    $error("out_dest: expected %0d, got %0d", want.to_peer, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("out_last: expected %0d, got %0d", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].val);
        end
        drain_results();

        write_binary_mode(1'b1);
        run_random(RANDOM_ITEMS);
        drain_results();

        src_idle_pct = 79;
        dst_idle_pct = 16;
        write_binary_mode(1'b0);
        run_random(RANDOM_ITEMS);
        drain_results();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        write_binary_mode(1'b1);
        run_random(RANDOM_ITEMS);
        drain_results();

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
